>>> sv/setpoint_profile_stabilization_sequencer_top_macros.svh
// assertion macros for the sequencer
`ifndef SETPOINT_PROFILE_STABILIZATION_SEQUENCER_TOP_MACROS_SVH
`define SETPOINT_PROFILE_STABILIZATION_SEQUENCER_TOP_MACROS_SVH
// implication checked on every clock outside reset
`define SPS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbl failed");
// next-cycle implication
`define SPS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbl failed");
`endif

>>> sv/spss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package spss_pkg;
    localparam int ProfileDepth = 16;
    localparam int TraceDepth = 128;
    localparam int FilterAlpha = 6554;
    localparam int TrW = $clog2(TraceDepth);

    typedef enum logic [2:0] {
        K_TICK = 3'd0, K_START = 3'd1, K_PAUSE = 3'd2, K_RESUME = 3'd3,
        K_ABORT = 3'd4, K_LOAD = 3'd5, K_BAD6 = 3'd6, K_BAD7 = 3'd7
    } kind_t;

    typedef enum logic [3:0] {
        M_IDLE = 4'd0, M_STARTING = 4'd1, M_MOVING = 4'd2, M_STABILIZING = 4'd3,
        M_DWELLING = 4'd4, M_STEPDONE = 4'd5, M_PAUSED = 4'd6, M_FINISHED = 4'd7,
        M_ABORTED = 4'd8, M_FAULT = 4'd9
    } mode_t;

    typedef enum logic [2:0] {
        C_BAND = 3'd0, C_SETTLE = 3'd1, C_POST = 3'd2, C_LIMIT = 3'd3,
        C_GOON = 3'd4, C_RATE = 3'd5, C_WIN = 3'd6, C_LEN = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        B_IDLE, B_RUN, B_SCAN, B_SREAD, B_SMUL, B_SCMP, B_OUT
    } bstate_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [31:0]        time_ms;
        logic               sensor_good;
        logic signed [15:0] raw_temp;
        logic               sensor_blocked;
        logic               is_armed;
        logic               arm_would_succeed;
        logic [3:0]         entry_index;
        logic signed [15:0] entry_setpoint;
    } in_word_t;

    typedef struct packed {
        logic [3:0]         run_state;
        logic [4:0]         step_number;
        logic signed [15:0] setpoint_out;
        logic signed [15:0] smoothed_temp;
        logic               arm_request;
        logic               disarm_request;
        logic               stabilized;
        logic               inside_band;
        logic               timed_out;
        logic               rate_ok;
        logic               accepted;
    } out_word_t;

    typedef struct packed {
        logic [14:0] band;
        logic [15:0] settle;
        logic [15:0] post;
        logic [15:0] limit;
        logic        goon;
        logic [23:0] rate;
        logic [11:0] win;
        logic [4:0]  len;
    } cfg_t;
endpackage
`default_nettype wire

>>> sv/spss_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module spss_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              valid,
    output logic                   stall,
    input  wire spss_pkg::in_word_t data,
    output logic                   q_valid,
    input  wire logic              q_take,
    output spss_pkg::in_word_t     q_data
);
    import spss_pkg::*;
    // two-entry fifo between front and back
    in_word_t mem_reg [2];
    logic rd_reg, rd_next, wr_reg, wr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic push, pop;

    assign stall = (cnt_reg == 2'd2);
    assign push = valid && !stall;
    assign q_valid = (cnt_reg != 2'd0);
    assign pop = q_valid && q_take;
    assign q_data = mem_reg[rd_reg];

    always_comb
    begin
        rd_next = pop ? ~rd_reg : rd_reg;
        wr_next = push ? ~wr_reg : wr_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            rd_reg <= rd_next;
            wr_reg <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= data;
    end
endmodule
`default_nettype wire

>>> sv/spss_exec.sv
`timescale 1ns / 1ps
`default_nettype none
module spss_exec (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire spss_pkg::cfg_t     cfg,
    input  wire logic               q_valid,
    output logic                    q_take,
    input  wire spss_pkg::in_word_t q_data,
    output logic                    valid,
    input  wire logic               stall,
    output spss_pkg::out_word_t     data
);
    import spss_pkg::*;

    bstate_t st_reg, st_next;
    mode_t mode_reg, mode_next, mbp_reg, mbp_next;
    logic [4:0] spos_reg, spos_next; // step plus one
    logic signed [15:0] asp_reg, asp_next;
    logic spv_reg, spv_next;
    logic signed [15:0] prof_mem [ProfileDepth];
    logic signed [15:0] fv_reg, fv_next;
    logic fp_reg, fp_next;
    logic [31:0] tt_mem [TraceDepth];
    logic signed [15:0] tv_mem [TraceDepth];
    logic [TrW-1:0] head_reg, head_next;
    logic [TrW:0] fill_reg, fill_next;
    logic [31:0] due_reg, due_next;
    logic sok_reg, sok_next;
    logic [31:0] tstep_reg, tstep_next, tband_reg, tband_next;
    logic [31:0] tdw_reg, tdw_next, tpau_reg, tpau_next;
    logic fstab_reg, fstab_next, fto_reg, fto_next, fband_reg, fband_next;
    logic arm_reg, arm_next, dis_reg, dis_next, acc_reg, acc_next;
    logic ov_reg, ov_next;
    in_word_t it_reg, it_next;
    // slope scan
    logic [TrW:0] si_reg, si_next;
    logic [31:0] nt_reg, nt_next;
    logic signed [15:0] ntemp_reg, ntemp_next;
    logic [31:0] rdt_reg;
    logic signed [15:0] rdv_reg;
    logic [TrW-1:0] raddr;
    logic [16:0] ad_reg, ad_next;
    logic [31:0] age_reg, age_next;
    logic [47:0] lhs_reg, lhs_next;
    logic [55:0] rhs_reg, rhs_next;
    logic tw_en;

    // filter helper values
    logic signed [16:0] diff;
    logic signed [34:0] prod;
    logic signed [34:0] prnd;
    logic signed [18:0] incr;
    logic [31:0] now;
    logic [31:0] win_ms;
    logic [TrW-1:0] newest;

    function automatic logic [31:0] since(input logic [31:0] s, input logic [31:0] n);
        since = (s == 32'd0 || n < s) ? 32'd0 : n - s;
    endfunction

    function automatic logic is_act(input mode_t m);
        is_act = (m inside {M_STARTING, M_MOVING, M_STABILIZING, M_DWELLING,
                            M_STEPDONE, M_PAUSED});
    endfunction

    logic [4:0] eff_len;
    assign eff_len = (cfg.len > 5'(ProfileDepth)) ? 5'(ProfileDepth) : cfg.len;

    logic rate_dis;
    assign rate_dis = (cfg.rate == 24'd0) || (cfg.win == 12'd0);

    assign now = it_reg.time_ms;
    assign win_ms = 32'(cfg.win) * 32'd1000;
    assign newest = head_reg - TrW'(1);
    assign raddr = newest - si_reg[TrW-1:0];

    assign diff = 17'(q_data.raw_temp) - 17'(fv_reg);
    assign prod = 35'(diff) * 35'(FilterAlpha);
    assign prnd = prod + 35'sd32768;
    assign incr = 19'(prnd >>> 16);

    logic inband;
    logic signed [16:0] bd;
    logic [16:0] bda;
    assign bd = 17'(fv_reg) - 17'(asp_reg);
    assign bda = bd[16] ? 17'(-bd) : bd;
    assign inband = fp_reg && spv_reg && (bda <= 17'(cfg.band));

    assign q_take = (st_reg == B_IDLE) && !ov_reg;
    assign valid = ov_reg;

    always_comb
    begin
        data.run_state = mode_reg;
        data.step_number = spos_reg;
        data.setpoint_out = asp_reg;
        data.smoothed_temp = fv_reg;
        data.arm_request = arm_reg;
        data.disarm_request = dis_reg;
        data.stabilized = fstab_reg;
        data.inside_band = fband_reg;
        data.timed_out = fto_reg;
        data.rate_ok = rate_dis || sok_reg;
        data.accepted = acc_reg;
    end

    always_comb
    begin
        logic tmo;
        logic [31:0] p;
        st_next = st_reg;
        mode_next = mode_reg; mbp_next = mbp_reg; spos_next = spos_reg;
        asp_next = asp_reg; spv_next = spv_reg; fv_next = fv_reg; fp_next = fp_reg;
        head_next = head_reg; fill_next = fill_reg; due_next = due_reg;
        sok_next = sok_reg; tstep_next = tstep_reg; tband_next = tband_reg;
        tdw_next = tdw_reg; tpau_next = tpau_reg; fstab_next = fstab_reg;
        fto_next = fto_reg; fband_next = fband_reg; arm_next = arm_reg;
        dis_next = dis_reg; acc_next = acc_reg; ov_next = ov_reg; it_next = it_reg;
        si_next = si_reg; nt_next = nt_reg; ntemp_next = ntemp_reg;
        ad_next = ad_reg; age_next = age_reg; lhs_next = lhs_reg; rhs_next = rhs_reg;
        tw_en = 1'b0; tmo = 1'b0; p = '0;
        if (ov_reg && !stall)
            ov_next = 1'b0;
        case (st_reg)
            B_IDLE:
            begin
                if (q_valid && !ov_reg)
                begin
                    it_next = q_data;
                    arm_next = 1'b0; dis_next = 1'b0; acc_next = 1'b0;
                    st_next = B_OUT;
                    case (kind_t'(q_data.kind))
                        K_TICK:
                        begin
                            // filter update here, sampling next state
                            if (q_data.sensor_good)
                            begin
                                fp_next = 1'b1;
                                fv_next = fp_reg ? 16'(fv_reg + incr) : q_data.raw_temp;
                            end
                            st_next = B_RUN;
                        end
                        K_START:
                        begin
                            if (!is_act(mode_reg) && eff_len != 5'd0)
                            begin
                                mbp_next = M_IDLE; spos_next = 5'd1;
                                asp_next = prof_mem[0]; spv_next = 1'b1;
                                fstab_next = 1'b0; fto_next = 1'b0; fband_next = 1'b0;
                                tstep_next = q_data.time_ms; tband_next = '0;
                                tdw_next = '0; tpau_next = '0;
                                head_next = '0; fill_next = '0; due_next = '0;
                                sok_next = 1'b0; fp_next = 1'b0; fv_next = '0;
                                arm_next = 1'b1;
                                if (!q_data.is_armed && !q_data.arm_would_succeed)
                                begin
                                    mode_next = M_FAULT; dis_next = 1'b1;
                                end
                                else
                                begin
                                    mode_next = M_STARTING; acc_next = 1'b1;
                                end
                            end
                        end
                        K_PAUSE:
                        begin
                            if (is_act(mode_reg) && mode_reg != M_PAUSED)
                            begin
                                mbp_next = mode_reg; tpau_next = q_data.time_ms;
                                mode_next = M_PAUSED; acc_next = 1'b1;
                            end
                        end
                        K_RESUME:
                        begin
                            if (mode_reg == M_PAUSED)
                            begin
                                p = since(tpau_reg, q_data.time_ms);
                                if (tstep_reg != 0) tstep_next = tstep_reg + p;
                                if (tband_reg != 0) tband_next = tband_reg + p;
                                if (tdw_reg != 0) tdw_next = tdw_reg + p;
                                tpau_next = '0; mode_next = mbp_reg; mbp_next = M_IDLE;
                                acc_next = 1'b1;
                            end
                        end
                        K_ABORT:
                        begin
                            mode_next = M_ABORTED; dis_next = 1'b1; tpau_next = '0;
                            acc_next = 1'b1;
                        end
                        K_LOAD:
                            acc_next = 1'b1;
                        default: ;
                    endcase
                end
            end
            B_RUN:
            begin
                st_next = B_OUT;
                // sample into history
                if (fp_reg && !(due_reg != 0 && now < due_reg))
                begin
                    tw_en = 1'b1;
                    head_next = head_reg + TrW'(1);
                    if (fill_reg < (TrW+1)'(TraceDepth))
                        fill_next = fill_reg + 1'b1;
                    due_next = now + 32'd1000;
                    sok_next = 1'b0;
                    nt_next = now; ntemp_next = fv_reg;
                    si_next = (TrW+1)'(1);
                    if (!rate_dis && fill_next >= (TrW+1)'(2))
                        st_next = B_SCAN;
                end
                // the control step runs after the scan, so it sees the
                // slope of the sample just taken
                if (st_next == B_OUT)
                    st_next = B_SMUL; // go to control
            end
            B_SCAN:
            begin
                if (si_reg >= fill_reg)
                    st_next = B_SMUL;
                else
                    st_next = B_SREAD;
            end
            B_SREAD:
            begin
                // read data now valid
                if (nt_reg < rdt_reg || (nt_reg - rdt_reg) < win_ms)
                begin
                    si_next = si_reg + 1'b1;
                    st_next = B_SCAN;
                end
                else
                begin
                    age_next = nt_reg - rdt_reg;
                    ad_next = (17'(ntemp_reg) - 17'(rdv_reg));
                    if (ad_next[16]) ad_next = 17'(-ad_next);
                    st_next = B_SCMP;
                end
            end
            B_SCMP:
            begin
                lhs_next = 48'(ad_reg) * 48'd15360000;
                rhs_next = 56'(cfg.rate) * 56'(age_reg);
                si_next = '0;
                st_next = B_SMUL;
            end
            B_SMUL:
            begin
                // si_reg==0 marks a pending compare result
                if (si_reg == '0)
                    sok_next = (56'(lhs_reg) <= rhs_reg);
                si_next = (TrW+1)'(1);
                st_next = B_OUT;
                if (it_reg.sensor_blocked && is_act(mode_reg))
                begin
                    mode_next = M_FAULT; dis_next = 1'b1; tpau_next = '0;
                end
                else
                begin
                    tmo = (cfg.limit != 0) && (tstep_reg != 0) && !fto_reg &&
                          (since(tstep_reg, now) >= 32'(cfg.limit) * 32'd1000);
                    case (mode_reg)
                        M_STARTING:
                        begin
                            arm_next = 1'b1;
                            if (!it_reg.is_armed && !it_reg.arm_would_succeed)
                            begin
                                mode_next = M_FAULT; dis_next = 1'b1; tpau_next = '0;
                            end
                            else
                                mode_next = M_MOVING;
                        end
                        M_STEPDONE:
                        begin
                            if (spos_reg >= eff_len)
                            begin
                                mode_next = M_FINISHED; dis_next = 1'b1; tpau_next = '0;
                            end
                            else
                            begin
                                spos_next = spos_reg + 1'b1;
                                asp_next = prof_mem[spos_reg[3:0]];
                                spv_next = 1'b1; tstep_next = now;
                                tband_next = '0; tdw_next = '0;
                                fstab_next = 1'b0; fto_next = 1'b0; fband_next = 1'b0;
                                mode_next = M_MOVING;
                            end
                        end
                        M_MOVING, M_STABILIZING, M_DWELLING:
                        begin
                            if (tmo)
                            begin
                                fto_next = 1'b1; fstab_next = 1'b0;
                                if (cfg.goon)
                                    mode_next = M_STEPDONE;
                                else
                                begin
                                    mode_next = M_ABORTED; dis_next = 1'b1; tpau_next = '0;
                                end
                            end
                            else if (mode_reg == M_MOVING)
                            begin
                                fband_next = inband;
                                if (inband)
                                begin
                                    tband_next = now; mode_next = M_STABILIZING;
                                end
                            end
                            else if (!inband)
                            begin
                                fband_next = 1'b0; tband_next = '0; mode_next = M_MOVING;
                                if (mode_reg == M_DWELLING)
                                begin
                                    fstab_next = 1'b0; tdw_next = '0;
                                end
                            end
                            else if (mode_reg == M_STABILIZING)
                            begin
                                fband_next = 1'b1;
                                if (since(tband_reg, now) >= 32'(cfg.settle) * 32'd1000
                                    && (rate_dis || sok_next))
                                begin
                                    fstab_next = 1'b1; tdw_next = now;
                                    mode_next = M_DWELLING;
                                end
                            end
                            else
                            begin
                                fband_next = 1'b1;
                                if (cfg.post == 0 ||
                                    since(tdw_reg, now) >= 32'(cfg.post) * 32'd1000)
                                    mode_next = M_STEPDONE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            B_OUT:
            begin
                ov_next = 1'b1;
                st_next = B_IDLE;
            end
            default: st_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= B_IDLE; mode_reg <= M_IDLE; mbp_reg <= M_IDLE;
            spos_reg <= '0; asp_reg <= '0; spv_reg <= 1'b0; fv_reg <= '0;
            fp_reg <= 1'b0; head_reg <= '0; fill_reg <= '0; due_reg <= '0;
            sok_reg <= 1'b0; tstep_reg <= '0; tband_reg <= '0; tdw_reg <= '0;
            tpau_reg <= '0; fstab_reg <= 1'b0; fto_reg <= 1'b0; fband_reg <= 1'b0;
            arm_reg <= 1'b0; dis_reg <= 1'b0; acc_reg <= 1'b0; ov_reg <= 1'b0;
            si_reg <= (TrW+1)'(1);
        end
        else
        begin
            st_reg <= st_next; mode_reg <= mode_next; mbp_reg <= mbp_next;
            spos_reg <= spos_next; asp_reg <= asp_next; spv_reg <= spv_next;
            fv_reg <= fv_next; fp_reg <= fp_next; head_reg <= head_next;
            fill_reg <= fill_next; due_reg <= due_next; sok_reg <= sok_next;
            tstep_reg <= tstep_next; tband_reg <= tband_next; tdw_reg <= tdw_next;
            tpau_reg <= tpau_next; fstab_reg <= fstab_next; fto_reg <= fto_next;
            fband_reg <= fband_next; arm_reg <= arm_next; dis_reg <= dis_next;
            acc_reg <= acc_next; ov_reg <= ov_next; si_reg <= si_next;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg <= it_next; nt_reg <= nt_next; ntemp_reg <= ntemp_next;
        ad_reg <= ad_next; age_reg <= age_next; lhs_reg <= lhs_next;
        rhs_reg <= rhs_next;
    end

    // history ring, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (tw_en)
        begin
            tt_mem[head_reg] <= now;
            tv_mem[head_reg] <= fv_reg;
        end
        rdt_reg <= tt_mem[raddr];
        rdv_reg <= tv_mem[raddr];
    end

    // profile table
    always_ff @(posedge clk)
    begin
        if (st_reg == B_IDLE && q_valid && !ov_reg &&
            kind_t'(q_data.kind) == K_LOAD)
            prof_mem[q_data.entry_index] <= q_data.entry_setpoint;
    end
endmodule
`default_nettype wire

>>> sv/setpoint_profile_stabilization_sequencer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// setpoint profile sequencer: a two-word input queue feeds a sequential back
// end that handles one word at a time. a command word goes from idle to the
// output state; a tick also passes the run and control states, plus a scan
// and a read state per history entry walked by the slope search when a
// once-per-second sample is taken, over at most the 128-entry ring; the
// single-port history read sets the pace of that walk. one result word per
// input word, held in an output register until taken.
module setpoint_profile_stabilization_sequencer_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire spss_pkg::in_word_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output spss_pkg::out_word_t      out_data,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [23:0]         cfg_data
);
    import spss_pkg::*;
    `include "setpoint_profile_stabilization_sequencer_top_macros.svh"

    cfg_t cfg_reg, cfg_next;
    logic q_valid, q_take;
    in_word_t q_data;

    // config register file, band tolerance clamped at its floor
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                C_BAND:   cfg_next.band = (cfg_data[14:0] < 15'd3) ? 15'd3 : cfg_data[14:0];
                C_SETTLE: cfg_next.settle = cfg_data[15:0];
                C_POST:   cfg_next.post = cfg_data[15:0];
                C_LIMIT:  cfg_next.limit = cfg_data[15:0];
                C_GOON:   cfg_next.goon = cfg_data[0];
                C_RATE:   cfg_next.rate = cfg_data;
                C_WIN:    cfg_next.win = cfg_data[11:0];
                C_LEN:    cfg_next.len = cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.band <= 15'd128;
            cfg_reg.settle <= 16'd300;
            cfg_reg.post <= 16'd300;
            cfg_reg.limit <= 16'd900;
            cfg_reg.goon <= 1'b0;
            cfg_reg.rate <= 24'd3277;
            cfg_reg.win <= 12'd60;
            cfg_reg.len <= 5'd6;
        end
        else
            cfg_reg <= cfg_next;
    end

    // front: queue of accepted words
    spss_queue u_queue (
        .clk(clk), .rst_n(rst_n), .valid(in_valid), .stall(in_stall),
        .data(in_data), .q_valid(q_valid), .q_take(q_take), .q_data(q_data)
    );

    // back: sequencer and slope unit
    spss_exec u_exec (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg), .q_valid(q_valid),
        .q_take(q_take), .q_data(q_data), .valid(out_valid),
        .stall(out_stall), .data(out_data)
    );

    // a held result must not change while stalled
    `SPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))
    // disarm is only requested together with a terminal state
    `SPS_ASSERT_IMPL(a_disarm_state, out_valid && out_data.disarm_request,
        out_data.run_state == M_FINISHED || out_data.run_state == M_ABORTED ||
        out_data.run_state == M_FAULT)
    // band tolerance never below its floor
    `SPS_ASSERT_IMPL(a_band_floor, 1'b1, cfg_reg.band >= 15'd3)
endmodule
`default_nettype wire

>>> tb/tb_setpoint_profile_stabilization_sequencer_top.sv
`timescale 1ns / 1ps
module tb_setpoint_profile_stabilization_sequencer_top;
    import spss_pkg::*;

    // cycles with no word moving on either side before the run is declared hung
    localparam int HangLimit = 20000;
    // quiet time after the last result before a register write or the end
    localparam int DrainCycles = 300;
    // length of the long receiver hold-off
    localparam int HoldCycles = 1500;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_word_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_word_t   out_data;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;

    setpoint_profile_stabilization_sequencer_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 8 ns clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // sequencer shadow: registers, run state, filter and slope history
    // ------------------------------------------------------------------
    int unsigned band_tol, settle_s, post_s, limit_s, goon, rate_lim, win_s, prof_len;
    mode_t       run_mode, paused_from;
    int          step_idx;
    int          cur_sp;
    bit          sp_valid;
    int          setpoints [ProfileDepth];
    int          ema;
    bit          ema_primed;
    int unsigned hist_ms [TraceDepth];
    int          hist_temp [TraceDepth];
    int unsigned hist_head, hist_fill;
    int unsigned sample_due;
    bit          slope_pass;
    int unsigned t_step, t_band, t_dwell, t_pause;
    bit          f_stab, f_timeout, f_band;
    bit          arm_req, disarm_req;

    // expected result words, oldest first
    out_word_t   pending_results [$];
    int          mismatches;
    int          words_sent;
    int          words_checked;
    int          runs_finished;
    int          faults_seen;

    // traffic shaping
    bit          idle_on;        // random gaps on both sides
    int          hold_reqs;      // requests for a long receiver hold-off
    int unsigned sim_ms;         // time stamp carried by the stimulus

    function automatic bit run_active();
        return run_mode >= M_STARTING && run_mode <= M_PAUSED;
    endfunction

    function automatic int unsigned elapsed_ms(int unsigned start, int unsigned now);
        if (start == 0 || now < start)
            return 0;
        return now - start;
    endfunction

    function automatic int unsigned steps_in_profile();
        return prof_len < ProfileDepth ? prof_len : ProfileDepth;
    endfunction

    function automatic void clear_run();
        run_mode = M_IDLE;
        paused_from = M_IDLE;
        step_idx = -1;
        cur_sp = 0;
        sp_valid = 0;
        f_stab = 0;
        f_timeout = 0;
        f_band = 0;
        t_step = 0;
        t_band = 0;
        t_dwell = 0;
        t_pause = 0;
        hist_head = 0;
        hist_fill = 0;
        sample_due = 0;
        slope_pass = 0;
        ema_primed = 0;
        ema = 0;
    endfunction

    function automatic void end_run(mode_t m);
        disarm_req = 1;
        run_mode = m;
        t_pause = 0;
    endfunction

    // newest history entry old enough decides the slope, by cross-multiplication
    function automatic void update_slope();
        int unsigned newest, idx, age, win_ms;
        int          d;
        slope_pass = 0;
        if (rate_lim == 0 || win_s == 0 || hist_fill < 2)
            return;
        newest = (hist_head + TraceDepth - 1) % TraceDepth;
        win_ms = win_s * 1000;
        for (int unsigned i = 1; i < hist_fill; i++) begin
            idx = (newest + TraceDepth - i) % TraceDepth;
            if (hist_ms[newest] < hist_ms[idx])
                continue;
            age = hist_ms[newest] - hist_ms[idx];
            if (age < win_ms)
                continue;
            d = hist_temp[newest] - hist_temp[idx];
            if (d < 0)
                d = -d;
            slope_pass = (longint'(d) * 64'd15360000) <= (longint'(rate_lim) * longint'(age));
            return;
        end
    endfunction

    function automatic void filter_and_log(int raw, bit good, int unsigned now);
        longint acc;
        if (good) begin
            if (!ema_primed) begin
                ema = raw;
                ema_primed = 1;
            end
            else begin
                // round to nearest, ties toward plus infinity
                acc = longint'(raw - ema) * FilterAlpha + 32768;
                ema += int'(acc >>> 16);
            end
        end
        if (!ema_primed)
            return;
        if (sample_due != 0 && now < sample_due)
            return;
        hist_ms[hist_head] = now;
        hist_temp[hist_head] = ema;
        hist_head = (hist_head + 1) % TraceDepth;
        if (hist_fill < TraceDepth)
            hist_fill++;
        sample_due = now + 1000;
        update_slope();
    endfunction

    function automatic bit in_band();
        int d;
        if (!ema_primed || !sp_valid)
            return 0;
        d = ema - cur_sp;
        if (d < 0)
            d = -d;
        return d <= int'(band_tol);
    endfunction

    function automatic bit slope_met();
        if (rate_lim == 0 || win_s == 0)
            return 1;
        return slope_pass;
    endfunction

    function automatic bit step_overrun(int unsigned now);
        if (limit_s == 0 || t_step == 0 || f_timeout)
            return 0;
        if (elapsed_ms(t_step, now) < limit_s * 1000)
            return 0;
        f_timeout = 1;
        f_stab = 0;
        if (goon)
            run_mode = M_STEPDONE;
        else
            end_run(M_ABORTED);
        return 1;
    endfunction

    function automatic void next_step(int unsigned now);
        int unsigned nxt;
        nxt = int'(step_idx + 1);
        if (nxt >= steps_in_profile()) begin
            end_run(M_FINISHED);
            return;
        end
        step_idx = nxt;
        cur_sp = setpoints[nxt];
        sp_valid = 1;
        t_step = now;
        t_band = 0;
        t_dwell = 0;
        f_stab = 0;
        f_timeout = 0;
        f_band = 0;
        run_mode = M_MOVING;
    endfunction

    function automatic void do_tick(in_word_t w);
        int unsigned now;
        now = w.time_ms;
        filter_and_log(int'($signed(w.raw_temp)), w.sensor_good, now);
        if (w.sensor_blocked && run_active()) begin
            end_run(M_FAULT);
            return;
        end
        case (run_mode)
            M_STARTING: begin
                arm_req = 1;
                if (!w.is_armed && !w.arm_would_succeed)
                    end_run(M_FAULT);
                else
                    run_mode = M_MOVING;
            end
            M_STEPDONE: next_step(now);
            M_MOVING: begin
                if (!step_overrun(now)) begin
                    f_band = in_band();
                    if (f_band) begin
                        t_band = now;
                        run_mode = M_STABILIZING;
                    end
                end
            end
            M_STABILIZING: begin
                if (!step_overrun(now)) begin
                    if (!in_band()) begin
                        f_band = 0;
                        t_band = 0;
                        run_mode = M_MOVING;
                    end
                    else begin
                        f_band = 1;
                        if (elapsed_ms(t_band, now) >= settle_s * 1000 && slope_met()) begin
                            f_stab = 1;
                            t_dwell = now;
                            run_mode = M_DWELLING;
                        end
                    end
                end
            end
            M_DWELLING: begin
                if (!step_overrun(now)) begin
                    if (!in_band()) begin
                        f_band = 0;
                        f_stab = 0;
                        t_band = 0;
                        t_dwell = 0;
                        run_mode = M_MOVING;
                    end
                    else begin
                        f_band = 1;
                        if (post_s == 0 || elapsed_ms(t_dwell, now) >= post_s * 1000)
                            run_mode = M_STEPDONE;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // expected result word for one accepted input word
    function automatic out_word_t sequencer_result(in_word_t w);
        out_word_t   r;
        bit          acc;
        int unsigned pause_len;
        acc = 0;
        arm_req = 0;
        disarm_req = 0;
        case (kind_t'(w.kind))
            K_TICK: do_tick(w);
            K_START: begin
                if (!run_active() && steps_in_profile() != 0) begin
                    clear_run();
                    step_idx = 0;
                    cur_sp = setpoints[0];
                    sp_valid = 1;
                    t_step = w.time_ms;
                    run_mode = M_STARTING;
                    arm_req = 1;
                    if (!w.is_armed && !w.arm_would_succeed)
                        end_run(M_FAULT);
                    else
                        acc = 1;
                end
            end
            K_PAUSE: begin
                if (run_active() && run_mode != M_PAUSED) begin
                    paused_from = run_mode;
                    t_pause = w.time_ms;
                    run_mode = M_PAUSED;
                    acc = 1;
                end
            end
            K_RESUME: begin
                if (run_mode == M_PAUSED) begin
                    pause_len = elapsed_ms(t_pause, w.time_ms);
                    if (t_step != 0)
                        t_step += pause_len;
                    if (t_band != 0)
                        t_band += pause_len;
                    if (t_dwell != 0)
                        t_dwell += pause_len;
                    t_pause = 0;
                    run_mode = paused_from;
                    paused_from = M_IDLE;
                    acc = 1;
                end
            end
            K_ABORT: begin
                end_run(M_ABORTED);
                acc = 1;
            end
            K_LOAD: begin
                setpoints[w.entry_index] = int'($signed(w.entry_setpoint));
                acc = 1;
            end
            default: ;
        endcase
        if (disarm_req && run_mode == M_FINISHED)
            runs_finished++;
        if (disarm_req && run_mode == M_FAULT)
            faults_seen++;
        r.run_state = run_mode;
        r.step_number = 5'(step_idx + 1);
        r.setpoint_out = 16'(cur_sp);
        r.smoothed_temp = 16'(ema);
        r.arm_request = arm_req;
        r.disarm_request = disarm_req;
        r.stabilized = f_stab;
        r.inside_band = f_band;
        r.timed_out = f_timeout;
        r.rate_ok = slope_met();
        r.accepted = acc;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // offer one word, predict it once the block takes it
    task automatic send_word(in_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        in_data = w;
        forever begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        pending_results.push_back(sequencer_result(w));
        words_sent++;
    endtask

    task automatic send(kind_t k, bit good = 1'b1, int raw = 0, bit blk = 1'b0,
                       bit armed = 1'b1, bit arm_ok = 1'b1, int idx = 0, int sp = 0);
        in_word_t w;
        w.kind = k;
        w.time_ms = sim_ms;
        w.sensor_good = good;
        w.raw_temp = 16'(raw);
        w.sensor_blocked = blk;
        w.is_armed = armed;
        w.arm_would_succeed = arm_ok;
        w.entry_index = 4'(idx);
        w.entry_setpoint = 16'(sp);
        send_word(w);
    endtask

    // drop valid and wait until every result is back and the block is quiet
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // register write, only called after a drain
    task automatic write_reg(cfg_idx_t idx, logic [23:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            C_BAND:   band_tol = (val[14:0] < 3) ? 3 : val[14:0];
            C_SETTLE: settle_s = val[15:0];
            C_POST:   post_s = val[15:0];
            C_LIMIT:  limit_s = val[15:0];
            C_GOON:   goon = val[0];
            C_RATE:   rate_lim = val[23:0];
            C_WIN:    win_s = val[11:0];
            C_LEN:    prof_len = val[4:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(int unsigned band, int unsigned settle, int unsigned post,
                            int unsigned lim, int unsigned go, int unsigned rate,
                            int unsigned win, int unsigned len);
        drain();
        write_reg(C_BAND, 24'(band));
        write_reg(C_SETTLE, 24'(settle));
        write_reg(C_POST, 24'(post));
        write_reg(C_LIMIT, 24'(lim));
        write_reg(C_GOON, 24'(go));
        write_reg(C_RATE, 24'(rate));
        write_reg(C_WIN, 24'(win));
        write_reg(C_LEN, 24'(len));
    endtask

    // ------------------------------------------------------------------
    // output side: random stalls plus an optional long hold-off
    // ------------------------------------------------------------------
    int stall_left;
    int hold_cycles;
    int hold_seen;
    always @(negedge clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_cycles <= HoldCycles - 1;
            out_stall <= 1'b1;
        end
        else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 99) < 30) begin
            // mostly short stalls, now and then a long one
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80)
                                                       : $urandom_range(0, 3);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // compare every taken result word with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result word with nothing expected: %p", out_data);
            end
            else begin
                if (out_data !== pending_results[0]) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("ERROR: result word %0d differs", words_checked);
                        $display("  expected %p", pending_results[0]);
                        $display("  actual   %p", out_data);
                    end
                end
                void'(pending_results.pop_front());
                words_checked++;
            end
        end
    end

    // hang detection: nothing moving on either side for too long
    int quiet_cycles;
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HangLimit) begin
            $display("ERROR: no word moved for %0d cycles", HangLimit);
            $display("tb_setpoint_profile_stabilization_sequencer_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // a temperature near the current setpoint, sometimes far off
    function automatic int near_setpoint();
        int spread, v;
        spread = int'(band_tol) * 2 + 4;
        if ($urandom_range(0, 9) == 0)
            v = int'($urandom_range(0, 65535)) - 32768;
        else
            v = cur_sp + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return v;
    endfunction

    // table fill with extremes, unknown kinds, refusals and each fault path
    task automatic test_directed();
        for (int i = 0; i < ProfileDepth; i++)
            send(K_LOAD, 1'b1, 0, 1'b0, 1'b1, 1'b1, i,
                 (i == 0) ? -32768 : (i == 1) ? 32767 : 5120 + 97 * i);
        send(K_BAD6);
        send(K_BAD7);
        send(K_PAUSE);
        send(K_RESUME);
        // arm refused on start
        sim_ms = 1000;
        send(K_START, 1'b1, 0, 1'b0, 1'b0, 1'b0);
        // start at time zero, so the step never times out
        sim_ms = 0;
        send(K_START);
        send(K_TICK, 1'b1, -32768);
        sim_ms = 32'hFFFF_FFFF;
        send(K_TICK, 1'b1, 32767);
        // start while a run is active is refused
        send(K_START);
        // tick in the starting state with a failed arm
        send(K_ABORT);
        send(K_START);
        send(K_TICK, 1'b0, 0, 1'b0, 1'b0, 1'b0);
        // sensor inhibit while active
        sim_ms = 5000;
        send(K_START);
        send(K_TICK, 1'b1, 100, 1'b1);
        send(K_ABORT);
        send(K_LOAD, 1'b1, 0, 1'b0, 1'b1, 1'b1, 0, 5000);
        send(K_LOAD, 1'b1, 0, 1'b0, 1'b1, 1'b1, 1, 5300);
    endtask

    // register extremes: clamp of the band, empty profile, oversize profile
    task automatic test_register_extremes();
        set_regs(0, 0, 0, 0, 1, 0, 0, 0);
        sim_ms = 2000;
        send(K_START);
        set_regs(32767, 65535, 65535, 65535, 0, 24'hFF_FFFF, 4095, 31);
        send(K_START);
        sim_ms += 700;
        send(K_TICK, 1'b1, cur_sp);
        send(K_TICK, 1'b1, cur_sp);
        send(K_PAUSE);
        send(K_PAUSE);
        sim_ms += 900;
        send(K_RESUME);
        send(K_ABORT);
    endtask

    // mostly well-formed runs with random content, some noise mixed in
    task automatic test_profile_runs(int items);
        int r;
        for (int n = 0; n < items; n++) begin
            r = $urandom_range(0, 99);
            if (!run_active()) begin
                if (r < 70)
                    send(K_START, 1'b1, 0, 1'b0, $urandom_range(0, 9) != 0,
                         $urandom_range(0, 9) != 0);
                else if (r < 80)
                    send(K_LOAD, 1'b1, 0, 1'b0, 1'b1, 1'b1, $urandom_range(0, 15),
                         4096 + $urandom_range(0, 2048));
                else if (r < 85)
                    send(kind_t'($urandom_range(2, 3)));
                else if (r < 90)
                    send(kind_t'($urandom_range(6, 7)));
                else begin
                    sim_ms += $urandom_range(0, 1500);
                    send(K_TICK, $urandom_range(0, 3) != 0, near_setpoint());
                end
            end
            else if (run_mode == M_PAUSED) begin
                sim_ms += $urandom_range(0, 3000);
                if (r < 60)
                    send(K_RESUME);
                else
                    send(K_TICK, 1'b1, near_setpoint());
            end
            else begin
                if (r < 82) begin
                    // mostly forward time, now and then a repeat or a step back
                    if (r == 0)
                        sim_ms -= $urandom_range(1, 500);
                    else
                        sim_ms += $urandom_range(0, 1400);
                    send(K_TICK, $urandom_range(0, 15) != 0, near_setpoint(),
                         $urandom_range(0, 59) == 0, $urandom_range(0, 1),
                         $urandom_range(0, 9) != 0);
                end
                else if (r < 87)
                    send(K_PAUSE);
                else if (r < 89)
                    send(K_ABORT);
                else if (r < 93)
                    send(K_LOAD, 1'b1, 0, 1'b0, 1'b1, 1'b1, $urandom_range(0, 15),
                         int'($urandom_range(0, 65535)) - 32768);
                else if (r < 96)
                    send(K_START);
                else
                    send(kind_t'($urandom_range(6, 7)));
            end
        end
    endtask

    // receiver holds off while the sender keeps pushing back to back
    task automatic test_backpressure();
        drain();
        idle_on = 0;
        hold_reqs++;
        send(K_START);
        for (int i = 0; i < 30; i++) begin
            sim_ms += 400;
            send(K_TICK, 1'b1, near_setpoint());
        end
        idle_on = 1;
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = C_BAND;
        cfg_data = '0;
        hold_reqs = 0;
        idle_on = 1;
        sim_ms = 0;
        mismatches = 0;
        words_sent = 0;
        words_checked = 0;
        runs_finished = 0;
        faults_seen = 0;
        // reset values of the registers
        band_tol = 128;
        settle_s = 300;
        post_s = 300;
        limit_s = 900;
        goon = 0;
        rate_lim = 3277;
        win_s = 60;
        prof_len = 6;
        for (int i = 0; i < ProfileDepth; i++)
            setpoints[i] = 0;
        clear_run();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_register_extremes();

        // short times so runs reach stabilizing, dwell and advance
        set_regs(200, 1, 1, 12, 1, 24'hFF_FFFF, 1, 4);
        test_profile_runs(90);
        set_regs(80, 2, 0, 6, 0, 3277, 2, 16);
        test_profile_runs(90);
        // no timeout, slope check off, shorter profile
        set_regs(600, 0, 2, 0, 1, 0, 0, 2);
        test_profile_runs(70);
        test_backpressure();
        // time stamps near the top of the range, wrapping during the run
        set_regs(3, 1, 1, 20, 1, 500000, 3, 31);
        sim_ms = 32'hFFFF_0000 + $urandom_range(0, 32'hFFFF);
        idle_on = 0;
        test_profile_runs(30);
        idle_on = 1;
        test_profile_runs(60);

        drain();
        $display("covered %0d words (%0d results checked), %0d runs finished, %0d faults",
                 words_sent, words_checked, runs_finished, faults_seen);
        $display("register extremes, pause and resume, timeouts and a long output hold-off");
        if (mismatches == 0 && pending_results.size() == 0)
            $display("tb_setpoint_profile_stabilization_sequencer_top: done, clean");
        else
            $display("tb_setpoint_profile_stabilization_sequencer_top: done, errors");
        $finish;
    end
endmodule
